FILE: sv/assert_macros.svh
// Assertion helpers included by address_region_lookup.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ARL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ARL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/arl_pkg.sv
package arl_pkg;

	localparam int ADDR_W  = 64;
	localparam int PERM_W  = 4;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;

	localparam logic [PERM_W-1:0] PERM_READ   = 4'h1;
	localparam logic [PERM_W-1:0] PERM_WRITE  = 4'h2;
	localparam logic [PERM_W-1:0] PERM_EXEC   = 4'h4;
	localparam logic [PERM_W-1:0] PERM_SHARED = 4'h8;
	localparam logic [PERM_W-1:0] PERM_RWX    = PERM_READ | PERM_WRITE | PERM_EXEC;
	localparam logic [PERM_W-1:0] PERM_TEXT   = PERM_READ | PERM_EXEC;

	localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK0,
		ST_ADDR,
		ST_CMP
	} state_t;

	typedef struct packed {
		logic               op;
		logic [INDEX_W-1:0] entry_index;
		logic [ADDR_W-1:0]  entry_start;
		logic [ADDR_W-1:0]  entry_stop;
		logic [PERM_W-1:0]  entry_perm;
		logic [ADDR_W-1:0]  address;
		logic               want_gap;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] region_start;
		logic [ADDR_W-1:0] region_stop;
		logic [PERM_W-1:0] region_perm;
		logic              hit;
		logic              readable;
		logic              text_only;
	} res_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] stop;
		logic [PERM_W-1:0] perm;
	} entry_t;

endpackage

FILE: sv/arl_ram.sv
module arl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/address_region_lookup.sv
// Address region lookup over a table of regions sorted by start address, held in one
// single-port-read RAM and never cleared: set entry_count only over slots already written.
// A write request is taken in idle. A lookup request is settled in ST_CHK0 when slot 0
// decides it, otherwise by P binary search probes (at most ceil(log2(count)), about 10
// for 1024 regions); each probe is a RAM read in ST_ADDR and a compare in ST_CMP on the
// shared address comparator pair. Requests are stalled while a lookup runs;
// a finished result waits in the output register while the next request is taken.
`include "assert_macros.svh"

module address_region_lookup #(
	parameter int ENTRIES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [arl_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  arl_pkg::req_t                 req,
	output logic                          res_valid,
	input  logic                          res_stall,
	output arl_pkg::res_t                 res
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	function automatic arl_pkg::res_t make_res(
		input logic [arl_pkg::ADDR_W-1:0] b,
		input logic [arl_pkg::ADDR_W-1:0] e,
		input logic [arl_pkg::PERM_W-1:0] perm,
		input logic                       h
	);
		arl_pkg::res_t r;
		r.region_start = b;
		r.region_stop  = e;
		r.region_perm  = perm;
		r.hit          = h;
		r.readable     = (perm & arl_pkg::PERM_READ) != '0;
		r.text_only    = (perm & arl_pkg::PERM_RWX) == arl_pkg::PERM_TEXT;
		return r;
	endfunction

	arl_pkg::state_t state_q, state_d;

	logic [arl_pkg::COUNT_W-1:0] count_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [arl_pkg::ADDR_W-1:0]  addr_q;
	logic                        gap_q;
	logic [CNT_W-1:0]            lo_q, hi_q;
	logic [IDX_W-1:0]            mid_q;
	logic [arl_pkg::ADDR_W-1:0]  lo_stop_q, hi_start_q;
	arl_pkg::res_t               res_q;
	logic                        res_valid_q;

	logic                        req_take;
	logic                        lookup_take;
	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [IDX_W-1:0]            ram_raddr;
	arl_pkg::entry_t             ram_wdata, rd;
	logic [CNT_W-1:0]            cnt_lim;
	logic [CNT_W:0]              mid_sum;
	logic [IDX_W-1:0]            mid_d;
	logic                        below_start, below_stop;
	logic                        empty0, hit0, search_on, out_ready;
	logic                        res_load, chk0_load, cmp_load;
	arl_pkg::res_t               res_d;

	// Shared comparator pair: every probe goes through these two compares.
	assign below_start = addr_q < rd.start;
	assign below_stop  = addr_q < rd.stop;

	assign req_take    = req_valid && !req_stall;
	assign lookup_take = req_take && (req.op == arl_pkg::OP_LOOKUP);
	assign req_stall   = state_q != arl_pkg::ST_IDLE;
	assign out_ready   = !res_valid_q || !res_stall;

	assign ram_we    = req_take && (req.op == arl_pkg::OP_WRITE) &&
	                   (32'(req.entry_index) < 32'(ENTRIES));
	assign ram_waddr = IDX_W'(req.entry_index);
	assign ram_wdata = '{start: req.entry_start, stop: req.entry_stop, perm: req.entry_perm};

	assign cnt_lim = (32'(count_q) > 32'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(count_q);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_d   = IDX_W'(mid_sum >> 1);

	assign empty0    = (addr_q == '0) || (cnt_q == '0) || below_start;
	assign hit0      = below_stop;
	assign search_on = lo_q <= hi_q;

	arl_ram #(
		.WIDTH($bits(arl_pkg::entry_t)),
		.DEPTH(ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arl_pkg::ST_IDLE: begin
				if (lookup_take) begin
					state_d = arl_pkg::ST_CHK0;
				end
			end
			arl_pkg::ST_CHK0: begin
				if (empty0 || hit0) begin
					if (out_ready) begin
						state_d = arl_pkg::ST_IDLE;
					end
				end else begin
					state_d = arl_pkg::ST_ADDR;
				end
			end
			arl_pkg::ST_ADDR: begin
				if (search_on) begin
					state_d = arl_pkg::ST_CMP;
				end else if (out_ready) begin
					state_d = arl_pkg::ST_IDLE;
				end
			end
			arl_pkg::ST_CMP: begin
				if (below_start || !below_stop) begin
					state_d = arl_pkg::ST_ADDR;
				end else if (out_ready) begin
					state_d = arl_pkg::ST_IDLE;
				end
			end
			default: state_d = arl_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ram_raddr = '0;
		res_load  = 1'b0;
		chk0_load = 1'b0;
		cmp_load  = 1'b0;
		res_d     = make_res('0, '0, '0, 1'b0);
		unique case (state_q)
			arl_pkg::ST_IDLE: begin
				ram_raddr = '0;
			end
			arl_pkg::ST_CHK0: begin
				ram_raddr = '0;
				if (empty0) begin
					res_load = out_ready;
				end else if (hit0) begin
					res_load = out_ready;
					res_d    = make_res(rd.start, rd.stop, rd.perm, 1'b1);
				end else begin
					chk0_load = 1'b1;
				end
			end
			arl_pkg::ST_ADDR: begin
				ram_raddr = mid_d;
				if (!search_on) begin
					res_load = out_ready;
					if (gap_q) begin
						res_d = make_res(lo_stop_q,
						                 (lo_q < cnt_q) ? hi_start_q : arl_pkg::ADDR_TOP,
						                 '0, 1'b0);
					end
				end
			end
			arl_pkg::ST_CMP: begin
				// Hold the probe address so the read data stays put while stalled.
				ram_raddr = mid_q;
				if (below_start || !below_stop) begin
					cmp_load = 1'b1;
				end else begin
					res_load = out_ready;
					res_d    = make_res(rd.start, rd.stop, rd.perm, 1'b1);
				end
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arl_pkg::ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_take) begin
			addr_q <= req.address;
			gap_q  <= req.want_gap;
			cnt_q  <= cnt_lim;
		end
		if (chk0_load) begin
			lo_q      <= CNT_W'(1);
			hi_q      <= cnt_q - CNT_W'(1);
			lo_stop_q <= rd.stop;
		end
		if ((state_q == arl_pkg::ST_ADDR) && search_on) begin
			mid_q <= mid_d;
		end
		if (cmp_load) begin
			if (below_start) begin
				hi_q       <= CNT_W'(mid_q) - CNT_W'(1);
				hi_start_q <= rd.start;
			end else begin
				lo_q      <= CNT_W'(mid_q) + CNT_W'(1);
				lo_stop_q <= rd.stop;
			end
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ARL_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (state_q == arl_pkg::ST_IDLE) && !res_valid_q, "reset leaves sequencer or result busy")
	`ARL_ASSERT(a_write_stays_idle, clk, arst_n, req_take && (req.op == arl_pkg::OP_WRITE) |=> state_q == arl_pkg::ST_IDLE, "write request started a search")
	`ARL_ASSERT(a_result_from_search, clk, arst_n, $rose(res_valid_q) |-> ($past(state_q) == arl_pkg::ST_CHK0) || ($past(state_q) == arl_pkg::ST_ADDR) || ($past(state_q) == arl_pkg::ST_CMP), "result appeared outside a search")
	`ARL_ASSERT(a_probe_in_range, clk, arst_n, state_q == arl_pkg::ST_CMP |-> (CNT_W'(mid_q) < cnt_q) && (mid_q != '0), "probe outside the searched slots")
	`ARL_ASSERT(a_miss_no_perm, clk, arst_n, res_valid_q && !res_q.hit |-> res_q.region_perm == '0, "miss result carries permissions")

endmodule

FILE: tb/tb_address_region_lookup.sv
`timescale 1ns / 1ps

module tb_address_region_lookup;
	import arl_pkg::*;

	localparam int DEPTH = 1024;
	localparam int SETTLE = 30;
	localparam int PHASES = 16;
	localparam int LOOKUPS_PER_PHASE = 30;
	localparam int HOLD_CYCLES = 400;
	localparam longint LIMIT = 1000000;

	typedef enum int {
		SHAPE_SPACED,
		SHAPE_PACKED,
		SHAPE_TOP,
		SHAPE_SCRAMBLED
	} layout_e;

	class region_scoreboard;
		entry_t      slots [DEPTH];
		int unsigned entry_count = 0;
		res_t        expected_regions [$];
		int          errors = 0;
		int          writes = 0;
		int          lookups = 0;
		int          hits = 0;

		function res_t make_region(logic [ADDR_W-1:0] lo_a, logic [ADDR_W-1:0] hi_a,
				logic [PERM_W-1:0] perm, logic found);
			res_t r;
			r.region_start = lo_a;
			r.region_stop = hi_a;
			r.region_perm = perm;
			r.hit = found;
			r.readable = (perm & PERM_READ) != '0;
			r.text_only = (perm & PERM_RWX) == PERM_TEXT;
			return r;
		endfunction

		// slot 0 first, then a binary search over slots 1 .. count-1
		function res_t find_region(logic [ADDR_W-1:0] addr, logic want_gap);
			int n, lo, hi, mid;
			n = (entry_count > DEPTH) ? DEPTH : entry_count;
			if (addr == '0 || n == 0 || addr < slots[0].start)
				return make_region('0, '0, '0, 1'b0);
			if (addr < slots[0].stop)
				return make_region(slots[0].start, slots[0].stop, slots[0].perm, 1'b1);
			lo = 1;
			hi = n - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (addr < slots[mid].start)
					hi = mid - 1;
				else if (addr >= slots[mid].stop)
					lo = mid + 1;
				else
					return make_region(slots[mid].start, slots[mid].stop, slots[mid].perm, 1'b1);
			end
			if (!want_gap)
				return make_region('0, '0, '0, 1'b0);
			return make_region(slots[hi].stop, (lo < n) ? slots[lo].start : ADDR_TOP, '0, 1'b0);
		endfunction

		function void note_request(req_t r);
			res_t exp_r;
			if (r.op == OP_WRITE) begin
				slots[r.entry_index].start = r.entry_start;
				slots[r.entry_index].stop = r.entry_stop;
				slots[r.entry_index].perm = r.entry_perm;
				writes++;
			end else begin
				exp_r = find_region(r.address, r.want_gap);
				expected_regions.push_back(exp_r);
				lookups++;
				if (exp_r.hit)
					hits++;
			end
		endfunction

		function void check_result(res_t got);
			res_t exp_r;
			logic bad;
			if (expected_regions.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: start %h stop %h perm %h hit %b",
						got.region_start, got.region_stop, got.region_perm, got.hit);
				return;
			end
			exp_r = expected_regions.pop_front();
			bad = got.region_start !== exp_r.region_start
				|| got.region_stop !== exp_r.region_stop
				|| got.region_perm !== exp_r.region_perm
				|| got.hit !== exp_r.hit
				|| got.readable !== exp_r.readable
				|| got.text_only !== exp_r.text_only;
			if (bad) begin
				errors++;
				if (errors <= 10) begin
					$display("lookup mismatch: exp start %h stop %h perm %h hit %b rd %b text %b",
						exp_r.region_start, exp_r.region_stop, exp_r.region_perm,
						exp_r.hit, exp_r.readable, exp_r.text_only);
					$display("                 got start %h stop %h perm %h hit %b rd %b text %b",
						got.region_start, got.region_stop, got.region_perm,
						got.hit, got.readable, got.text_only);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	res_t               res;

	logic hold_res = 1'b0;
	bit   pressure_arm = 1'b0;
	int   send_pct = 0;
	int   stall_pct = 0;
	int   settings = 0;
	longint cycles = 0;

	region_scoreboard sb;

	address_region_lookup #(.ENTRIES(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #4 clk = ~clk;

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_address_region_lookup: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);
		res_stall <= hold_res || ($urandom_range(99) < stall_pct);
	end

	// hold the result side off long enough for requests to back up
	initial begin
		wait (pressure_arm);
		@(posedge clk);
		hold_res <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_res <= 1'b0;
	end

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t lookup_req(logic [ADDR_W-1:0] addr, logic want_gap);
		req_t r;
		r.op = OP_LOOKUP;
		r.entry_index = $urandom;
		r.entry_start = rand64();
		r.entry_stop = rand64();
		r.entry_perm = $urandom;
		r.address = addr;
		r.want_gap = want_gap;
		return r;
	endfunction

	function automatic req_t write_req(int idx, logic [ADDR_W-1:0] lo_a,
			logic [ADDR_W-1:0] hi_a, logic [PERM_W-1:0] perm);
		req_t r;
		r.op = OP_WRITE;
		r.entry_index = idx[INDEX_W-1:0];
		r.entry_start = lo_a;
		r.entry_stop = hi_a;
		r.entry_perm = perm;
		r.address = rand64();
		r.want_gap = $urandom;
		return r;
	endfunction

	// aim at region edges, gaps and the ends of the address space
	function automatic logic [ADDR_W-1:0] pick_address(int n);
		int k;
		entry_t e;
		if (n == 0)
			return rand64() >> $urandom_range(63);
		k = $urandom_range(n - 1);
		e = sb.slots[k];
		case ($urandom_range(11))
			0: return '0;
			1: return ADDR_TOP;
			2: return rand64();
			3: return sb.slots[0].start - 1;
			4: return e.start;
			5: return e.stop - 1;
			6: return e.stop;
			7: return e.stop + (rand64() >> $urandom_range(40, 63));
			8: return sb.slots[n-1].stop + (rand64() >> $urandom_range(0, 63));
			default: begin
				if (e.stop > e.start)
					return e.start + rand64() % (e.stop - e.start);
				return e.start;
			end
		endcase
	endfunction

	task automatic send_request(req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.expected_regions.size() != 0)
			@(posedge clk);
		// let a trailing table write land
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(int unsigned n);
		drain();
		cfg_wdata <= n[COUNT_W-1:0];
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.entry_count = n;
		settings++;
	endtask

	task automatic load_layout(int n, layout_e shape);
		entry_t fresh [DEPTH];
		logic [ADDR_W-1:0] cursor, gap, len, shift_by;
		int scale;
		scale = $urandom_range(4, 48);
		cursor = ($urandom_range(9) == 0) ? '0 : (rand64() >> $urandom_range(8, 63));
		for (int i = 0; i < n; i++) begin
			if (shape == SHAPE_SCRAMBLED) begin
				fresh[i].start = rand64() >> $urandom_range(0, 8);
				fresh[i].stop = ($urandom_range(3) == 0) ? fresh[i].start : rand64();
			end else begin
				if ((shape == SHAPE_PACKED && i > 0) || $urandom_range(3) == 0)
					gap = '0;
				else
					gap = 1 + (rand64() >> (64 - scale));
				len = 1 + (rand64() >> (64 - scale));
				fresh[i].start = cursor + gap;
				fresh[i].stop = fresh[i].start + len;
				cursor = fresh[i].stop;
			end
			fresh[i].perm = $urandom;
		end
		// slide the whole layout up so the last region ends at the top
		if (shape == SHAPE_TOP) begin
			shift_by = ADDR_TOP - fresh[n-1].stop;
			for (int i = 0; i < n; i++) begin
				fresh[i].start += shift_by;
				fresh[i].stop += shift_by;
			end
		end
		for (int i = 0; i < n; i++)
			send_request(write_req(i, fresh[i].start, fresh[i].stop, fresh[i].perm));
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every slot gets written once, so any count is safe from here on
		load_layout(DEPTH, SHAPE_SPACED);

		// empty table
		send_request(lookup_req('0, 1'b1));
		send_request(lookup_req(ADDR_TOP, 1'b1));
		send_request(lookup_req(sb.slots[5].start, 1'b1));

		set_count(1);
		send_request(lookup_req(sb.slots[0].start - 1, 1'b1));
		send_request(lookup_req(sb.slots[0].start, 1'b0));
		send_request(lookup_req(sb.slots[0].stop - 1, 1'b1));
		send_request(lookup_req(sb.slots[0].stop, 1'b0));
		send_request(lookup_req(sb.slots[0].stop, 1'b1));
		send_request(lookup_req('0, 1'b1));

		// above the table size: clamps to the full table
		set_count(2047);
		send_request(lookup_req(sb.slots[DEPTH-1].start, 1'b0));
		send_request(lookup_req(ADDR_TOP, 1'b1));
		send_request(lookup_req(sb.slots[512].stop, 1'b1));
		send_request(lookup_req(sb.slots[300].stop - 1, 1'b0));
		send_request(write_req(DEPTH - 1, sb.slots[DEPTH-1].start, ADDR_TOP, PERM_TEXT));
		send_request(lookup_req(ADDR_TOP - 1, 1'b0));
		send_request(lookup_req(ADDR_TOP, 1'b1));

		for (int p = 0; p < PHASES; p++) begin
			int n, live;
			case (p % 4)
				0: begin send_pct = 0; stall_pct = 0; end
				1: begin send_pct = 52; stall_pct = 0; end
				2: begin send_pct = 0; stall_pct = 52; end
				default: begin send_pct = 24; stall_pct = 24; end
			endcase
			case (p)
				3: n = 0;
				6: n = DEPTH;
				9: n = 2047;
				12: n = $urandom_range(DEPTH + 1, 2047);
				default: n = ($urandom_range(4) == 0) ? $urandom_range(49, DEPTH)
					: $urandom_range(1, 48);
			endcase
			set_count(n);
			live = (n > DEPTH) ? DEPTH : n;
			if (live > 0 && live <= 64)
				load_layout(live, layout_e'($urandom_range(3)));
			if (p == 0)
				pressure_arm = 1'b1;
			for (int i = 0; i < LOOKUPS_PER_PHASE; i++) begin
				if ($urandom_range(9) == 0)
					send_request(write_req($urandom_range(DEPTH - 1), rand64(), rand64(),
						$urandom));
				send_request(lookup_req(pick_address(live), $urandom_range(1)));
			end
		end

		drain();
		$display("covered %0d table writes and %0d lookups (%0d hits) over %0d count settings",
			sb.writes, sb.lookups, sb.hits, settings);
		$display("counts included empty, single, full and clamped tables; %0d errors", sb.errors);
		if (sb.errors == 0)
			$display("tb_address_region_lookup: PASS");
		else
			$display("tb_address_region_lookup: FAIL");
		$finish;
	end

endmodule
